>>> hw/rtl/qbs_pkg.sv
// Shared types and constants of the quadratic B-spline path sampler.
`default_nettype none
package qbs_pkg;

  localparam int COORD_BITS  = 32;
  localparam int MAX_SAMPLES = 31;
  localparam int S_BITS      = 5;
  localparam int SQ_BITS     = 2 * S_BITS;
  localparam int W_BITS      = SQ_BITS + 1;
  localparam int DEN_BITS    = SQ_BITS + 1;
  localparam int NUM_W       = COORD_BITS + W_BITS + 1;
  localparam int MAG_W       = NUM_W - 1;
  localparam int JOB_DEPTH   = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [S_BITS-1:0] scount_t;

  typedef enum logic [1:0] {
    BASIS_START  = 2'd0,
    BASIS_MID    = 2'd1,
    BASIS_END    = 2'd2,
    BASIS_BEZIER = 2'd3
  } basis_t;

  typedef struct packed {
    coord_t  p0x;
    coord_t  p0y;
    coord_t  p1x;
    coord_t  p1y;
    coord_t  p2x;
    coord_t  p2y;
    basis_t  basis;
    logic    fin;
    logic    short_path;
    scount_t s;
  } job_t;

endpackage
`default_nettype wire

>>> hw/rtl/quadratic_bspline_path_sampler.sv
// Top level of the streaming quadratic B-spline path sampler.
// Control points go in through push/full and curve samples come out through
// empty/pop. Every point from the third on closes a three-point window that
// yields S+1 samples for the first segment of a path and S samples after it,
// where S is cfg_sample_count (zero acts as one). In the back end each sample
// goes through a weight step, a multiply-accumulate step per control point, a
// rounding step, the bit-serial divider by 2*S*S and an output step that waits
// while the previous sample has not been popped. Picking up a job from the
// queue is a step of its own before a segment's first sample. A two-entry job
// queue lets the next points be taken while a segment is still being sampled;
// when it is full, full is high. A path that ends before its third point gives
// one result with short_path set.
`default_nettype none
module quadratic_bspline_path_sampler import qbs_pkg::*; (
  input  wire     clk,
  input  wire     rst_n,
  input  wire     cfg_wr_en,
  input  scount_t cfg_sample_count,
  input  wire     push,
  output logic    full,
  input  coord_t  in_point_x,
  input  coord_t  in_point_y,
  input  wire     in_final_point,
  output logic    empty,
  input  wire     pop,
  output coord_t  out_sample_x,
  output coord_t  out_sample_y,
  output logic    out_run_end,
  output logic    out_path_end,
  output logic    out_short_path
);

  scount_t sample_count_r;
  logic    accept, job_wr, job_full, job_empty, job_rd, out_valid;
  job_t    job_w, job_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= S_BITS'(10);
    end else if (cfg_wr_en) begin
      sample_count_r <= cfg_sample_count;
    end
  end

  assign full   = job_full;
  assign accept = push && !job_full;
  assign empty  = !out_valid;

  qbs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .point_x      (in_point_x),
    .point_y      (in_point_y),
    .final_point  (in_final_point),
    .sample_count (sample_count_r),
    .job_wr       (job_wr),
    .job          (job_w)
  );

  qbs_job_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_wr),
    .wr_job (job_w),
    .full   (job_full),
    .rd_en  (job_rd),
    .rd_job (job_head),
    .empty  (job_empty)
  );

  qbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_empty  (job_empty),
    .job_in     (job_head),
    .job_rd     (job_rd),
    .out_valid  (out_valid),
    .out_take   (pop),
    .sample_x   (out_sample_x),
    .sample_y   (out_sample_y),
    .run_end    (out_run_end),
    .path_end   (out_path_end),
    .short_path (out_short_path)
  );

endmodule
`default_nettype wire

>>> hw/rtl/qbs_job_fifo.sv
// Two-entry queue of segment jobs between the front and the back.
`default_nettype none
module qbs_job_fifo import qbs_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  wr_en,
  input  job_t wr_job,
  output logic full,
  input  wire  rd_en,
  output job_t rd_job,
  output logic empty
);

  localparam int PTR_W = $clog2(JOB_DEPTH);
  localparam int CNT_W = $clog2(JOB_DEPTH + 1);

  job_t             mem_r [JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full   = (cnt_r == CNT_W'(JOB_DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/qbs_front.sv
// Front end: takes control points, keeps the window and queues segment jobs.
`default_nettype none
module qbs_front import qbs_pkg::*; (
  input  wire     clk,
  input  wire     rst_n,
  input  wire     accept,
  input  coord_t  point_x,
  input  coord_t  point_y,
  input  wire     final_point,
  input  scount_t sample_count,
  output logic    job_wr,
  output job_t    job
);

  coord_t      old_x_r, old_y_r, new_x_r, new_y_r;
  logic [1:0]  seen_r;
  scount_t     s_eff;
  logic        have_two;

  always_comb begin
    if (sample_count == '0) begin
      s_eff = S_BITS'(1);
    end else if (sample_count > S_BITS'(MAX_SAMPLES)) begin
      s_eff = S_BITS'(MAX_SAMPLES);
    end else begin
      s_eff = sample_count;
    end
  end

  assign have_two = (seen_r >= 2'd2);

  always_comb begin
    job.p0x        = old_x_r;
    job.p0y        = old_y_r;
    job.p1x        = new_x_r;
    job.p1y        = new_y_r;
    job.p2x        = point_x;
    job.p2y        = point_y;
    job.fin        = final_point;
    job.short_path = !have_two;
    job.s          = s_eff;
    if (seen_r == 2'd2) begin
      job.basis = final_point ? BASIS_BEZIER : BASIS_START;
    end else begin
      job.basis = final_point ? BASIS_END : BASIS_MID;
    end
  end

  // A point before the third makes no job unless it ends the path.
  assign job_wr = accept && (have_two || final_point);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_x_r <= '0;
      old_y_r <= '0;
      new_x_r <= '0;
      new_y_r <= '0;
      seen_r  <= '0;
    end else if (accept) begin
      if (final_point) begin
        old_x_r <= '0;
        old_y_r <= '0;
        new_x_r <= '0;
        new_y_r <= '0;
        seen_r  <= '0;
      end else begin
        old_x_r <= new_x_r;
        old_y_r <= new_y_r;
        new_x_r <= point_x;
        new_y_r <= point_y;
        seen_r  <= (seen_r == 2'd3) ? 2'd3 : seen_r + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/qbs_back.sv
// Back end: sweeps each segment over k, blends, rounds, divides and saturates.
`default_nettype none
module qbs_back import qbs_pkg::*; (
  input  wire    clk,
  input  wire    rst_n,
  input  wire    job_empty,
  input  job_t   job_in,
  output logic   job_rd,
  output logic   out_valid,
  input  wire    out_take,
  output coord_t sample_x,
  output coord_t sample_y,
  output logic   run_end,
  output logic   path_end,
  output logic   short_path
);

  localparam int WT_W  = SQ_BITS + 4;
  localparam int CNT_W = $clog2(MAG_W + 1);
  localparam logic [MAG_W-1:0] Q_LIM = MAG_W'(1) << (COORD_BITS - 1);
  localparam logic [MAG_W-1:0] Q_MAX = Q_LIM - 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WEIGHT = 6'b000010,
    ST_MAC    = 6'b000100,
    ST_PREP   = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  job_t                 job_r;
  scount_t              k_r;
  logic [SQ_BITS-1:0]   s2_r;
  logic [W_BITS-1:0]    w_r [3];
  logic [1:0]           mac_idx_r;
  logic signed [NUM_W-1:0] acc_x_r, acc_y_r;
  logic                 neg_x_r, neg_y_r;
  logic [MAG_W-1:0]     dvd_x_r, dvd_y_r;
  logic [DEN_BITS-1:0]  rem_x_r, rem_y_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 out_valid_r;
  coord_t               out_x_r, out_y_r;
  logic                 out_run_r, out_path_r, out_short_r;

  logic signed [WT_W-1:0] ke, se, re, kk, ks, ss, rr, kr;
  logic signed [WT_W-1:0] w0_c, w1_c, w2_c;
  logic [DEN_BITS-1:0]  den;
  logic [DEN_BITS:0]    tx, ty;
  logic                 qx, qy, out_free, last_k;
  coord_t               px_sel, py_sel, sat_x, sat_y;
  logic [W_BITS-1:0]    w_sel;
  logic signed [NUM_W-1:0] wext, prod_x, prod_y;

  always_comb begin
    ke = WT_W'(k_r);
    se = WT_W'(job_r.s);
    re = se - ke;
    kk = ke * ke;
    ks = ke * se;
    ss = se * se;
    rr = re * re;
    kr = ke * re;
    unique case (job_r.basis)
      BASIS_START: begin
        w0_c = rr <<< 1;
        w1_c = (ks <<< 2) - kk - (kk <<< 1);
        w2_c = kk;
      end
      BASIS_MID: begin
        w0_c = rr;
        w1_c = ss + (ks <<< 1) - (kk <<< 1);
        w2_c = kk;
      end
      BASIS_END: begin
        w0_c = rr;
        w1_c = ss + (ks <<< 1) - kk - (kk <<< 1);
        w2_c = kk <<< 1;
      end
      BASIS_BEZIER: begin
        w0_c = rr <<< 1;
        w1_c = kr <<< 2;
        w2_c = kk <<< 1;
      end
      default: begin
        w0_c = '0;
        w1_c = '0;
        w2_c = '0;
      end
    endcase
  end

  always_comb begin
    unique case (mac_idx_r)
      2'd0: begin
        px_sel = job_r.p0x;
        py_sel = job_r.p0y;
        w_sel  = w_r[0];
      end
      2'd1: begin
        px_sel = job_r.p1x;
        py_sel = job_r.p1y;
        w_sel  = w_r[1];
      end
      default: begin
        px_sel = job_r.p2x;
        py_sel = job_r.p2y;
        w_sel  = w_r[2];
      end
    endcase
    wext   = signed'(NUM_W'(w_sel));
    prod_x = NUM_W'(px_sel) * wext;
    prod_y = NUM_W'(py_sel) * wext;
  end

  // Restoring division by 2*S*S, one quotient bit per cycle on each axis.
  assign den = {s2_r, 1'b0};
  assign tx  = {rem_x_r, dvd_x_r[MAG_W-1]};
  assign ty  = {rem_y_r, dvd_y_r[MAG_W-1]};
  assign qx  = (tx >= {1'b0, den});
  assign qy  = (ty >= {1'b0, den});

  always_comb begin
    if (neg_x_r) begin
      sat_x = (dvd_x_r >= Q_LIM) ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                 : -dvd_x_r[COORD_BITS-1:0];
    end else begin
      sat_x = (dvd_x_r > Q_MAX) ? {1'b0, {(COORD_BITS-1){1'b1}}}
                                : dvd_x_r[COORD_BITS-1:0];
    end
    if (neg_y_r) begin
      sat_y = (dvd_y_r >= Q_LIM) ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                 : -dvd_y_r[COORD_BITS-1:0];
    end else begin
      sat_y = (dvd_y_r > Q_MAX) ? {1'b0, {(COORD_BITS-1){1'b1}}}
                                : dvd_y_r[COORD_BITS-1:0];
    end
  end

  assign out_free = !out_valid_r || out_take;
  assign last_k   = (k_r == job_r.s);
  assign job_rd   = (state_r == ST_IDLE) && !job_empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (!job_empty) state_nxt = job_in.short_path ? ST_OUT : ST_WEIGHT;
      ST_WEIGHT: state_nxt = ST_MAC;
      ST_MAC:    if (mac_idx_r == 2'd2) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == '0) state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = (job_r.short_path || last_k) ? ST_IDLE : ST_WEIGHT;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        job_r <= job_in;
        s2_r  <= SQ_BITS'(job_in.s) * SQ_BITS'(job_in.s);
        k_r   <= (job_in.basis == BASIS_START || job_in.basis == BASIS_BEZIER)
                 ? '0 : S_BITS'(1);
      end
      ST_WEIGHT: begin
        w_r[0]    <= w0_c[W_BITS-1:0];
        w_r[1]    <= w1_c[W_BITS-1:0];
        w_r[2]    <= w2_c[W_BITS-1:0];
        mac_idx_r <= '0;
        acc_x_r   <= '0;
        acc_y_r   <= '0;
      end
      ST_MAC: begin
        acc_x_r   <= acc_x_r + prod_x;
        acc_y_r   <= acc_y_r + prod_y;
        mac_idx_r <= mac_idx_r + 1'b1;
      end
      ST_PREP: begin
        // Round half away from zero by adding S*S to the magnitude.
        neg_x_r <= acc_x_r[NUM_W-1];
        neg_y_r <= acc_y_r[NUM_W-1];
        dvd_x_r <= (acc_x_r[NUM_W-1] ? MAG_W'(-acc_x_r) : MAG_W'(acc_x_r)) + MAG_W'(s2_r);
        dvd_y_r <= (acc_y_r[NUM_W-1] ? MAG_W'(-acc_y_r) : MAG_W'(acc_y_r)) + MAG_W'(s2_r);
        rem_x_r <= '0;
        rem_y_r <= '0;
        cnt_r   <= CNT_W'(MAG_W - 1);
      end
      ST_DIV: begin
        rem_x_r <= qx ? DEN_BITS'(tx - {1'b0, den}) : tx[DEN_BITS-1:0];
        rem_y_r <= qy ? DEN_BITS'(ty - {1'b0, den}) : ty[DEN_BITS-1:0];
        dvd_x_r <= {dvd_x_r[MAG_W-2:0], qx};
        dvd_y_r <= {dvd_y_r[MAG_W-2:0], qy};
        cnt_r   <= cnt_r - 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          out_x_r     <= job_r.short_path ? '0 : sat_x;
          out_y_r     <= job_r.short_path ? '0 : sat_y;
          out_run_r   <= job_r.short_path || last_k;
          out_path_r  <= job_r.short_path || (last_k && job_r.fin);
          out_short_r <= job_r.short_path;
          k_r         <= k_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign sample_x   = out_x_r;
  assign sample_y   = out_y_r;
  assign run_end    = out_run_r;
  assign path_end   = out_path_r;
  assign short_path = out_short_r;

endmodule
`default_nettype wire
